// ===== rtl/core/msmx_pkg.sv =====
`default_nettype none
package msmx_pkg;

  localparam int MaxElemsDefault = 64;
  localparam int ValueW = 16;
  localparam int ProbW = 16;
  localparam int ColsW = 7;
  localparam int SumW = 22;
  localparam int ExpW = 16;
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_NOT_MULTIPLE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_BY_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_INIT,
    ST_MAX_RD,
    ST_MAX_UPD,
    ST_SUM_RD,
    ST_SUM_EXP,
    ST_SUM_UPD,
    ST_OUT_RD,
    ST_OUT_EXP,
    ST_OUT_DIV,
    ST_OUT_SEND,
    ST_ERR_SEND
  } state_t;

  function automatic logic [15:0] pow2_tab(input logic [4:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0: v = 16'd32768;
      5'd1: v = 16'd31379;
      5'd2: v = 16'd30048;
      5'd3: v = 16'd28774;
      5'd4: v = 16'd27554;
      5'd5: v = 16'd26386;
      5'd6: v = 16'd25268;
      5'd7: v = 16'd24196;
      5'd8: v = 16'd23170;
      5'd9: v = 16'd22188;
      5'd10: v = 16'd21247;
      5'd11: v = 16'd20347;
      5'd12: v = 16'd19484;
      5'd13: v = 16'd18658;
      5'd14: v = 16'd17867;
      5'd15: v = 16'd17109;
      default: v = 16'd16384;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/matrix_softmax_top.sv =====
// channel | signals                            | beat
// in      | valid ready value last             | one matrix element
// out     | out_valid out_ready prob last_out status | one result
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | one register write
// Loading takes each valid element; ready stays high while loading.
// After last come a count check, a group clear over the elements,
// a max pass, a sum pass and an output pass that runs a 39-step
// restoring divider per element; output stalls can hold that pass.
// Reset (rst, synchronous) returns to loading with count and overflow clear.
// A stalled output holds its result; no element is taken until all are sent.
`default_nettype none
module matrix_softmax_top #(
  parameter int MAX_ELEMS = msmx_pkg::MaxElemsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        valid,
  output logic                             ready,
  input  wire logic signed [15:0]          value,
  input  wire logic                        last,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [15:0]                      prob,
  output logic                             last_out,
  output logic [1:0]                       status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [6:0]                  cfg_data
);
  import msmx_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  state_t state, state_next;
  logic by_rows;
  logic [6:0] num_cols;
  logic [15:0] store [MAX_ELEMS];
  logic [15:0] gmax [64];
  logic [21:0] gsum [64];
  logic [CW-1:0] count;
  logic ovf;
  logic [CW-1:0] idx;
  logic [6:0] col;
  logic [5:0] row;
  logic [5:0] grp;
  logic [15:0] rd_x;
  logic [15:0] rd_max;
  logic [21:0] rd_sum;
  logic [15:0] ex;
  logic exp_start;
  logic div_start;
  logic div_done;
  logic div_run;
  logic [15:0] div_prob;
  logic [15:0] prob_q;
  logic [1:0] err_code;
  logic [6:0] rem_chk;
  logic [CW-1:0] chk_cnt;
  logic in_acc;
  logic idx_last;

  assign ready = (state == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign in_acc = valid && ready;
  assign grp = by_rows ? row : col[5:0];
  assign idx_last = (idx + CW'(1) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      by_rows <= 1'b1;
      num_cols <= 7'd10;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_BY_ROWS: by_rows <= cfg_data[0];
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && count < CW'(MAX_ELEMS)) begin
      store[count[AW-1:0]] <= value;
    end
    rd_x <= store[idx[AW-1:0]];
    rd_max <= gmax[grp];
    rd_sum <= gsum[grp];
    if (state == ST_INIT) begin
      gmax[grp] <= 16'h8000;
      gsum[grp] <= '0;
    end else if (state == ST_MAX_UPD && $signed(rd_x) > $signed(rd_max)) begin
      gmax[grp] <= rd_x;
    end else if (state == ST_SUM_UPD) begin
      gsum[grp] <= rd_sum + {6'd0, ex};
    end
  end

  msmx_exp u_exp (
    .clk(clk), .start(exp_start), .x(rd_x), .mx(rd_max), .e(ex)
  );

  msmx_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .e(ex), .s(rd_sum),
    .done(div_done), .prob(div_prob)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf <= 1'b0;
      idx <= '0;
      col <= '0;
      row <= '0;
      err_code <= STATUS_OK;
      chk_cnt <= '0;
      rem_chk <= '0;
      div_run <= 1'b0;
    end else begin
      state <= state_next;
      if (div_start) begin
        div_run <= 1'b1;
      end else if (div_done) begin
        div_run <= 1'b0;
      end
      if (in_acc) begin
        if (count < CW'(MAX_ELEMS)) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
        chk_cnt <= '0;
        rem_chk <= '0;
        idx <= '0;
        col <= '0;
        row <= '0;
      end
      unique case (state)
        ST_CHECK: begin
          // walk count against num_cols one element at a time
          if (chk_cnt != count) begin
            chk_cnt <= chk_cnt + CW'(1);
            rem_chk <= (rem_chk + 7'd1 == num_cols) ? 7'd0 : rem_chk + 7'd1;
          end else if (ovf) begin
            err_code <= STATUS_OVERFLOW;
          end else if (num_cols == '0 || rem_chk != '0) begin
            err_code <= STATUS_NOT_MULTIPLE;
          end
        end
        ST_INIT, ST_MAX_UPD, ST_SUM_UPD, ST_OUT_SEND: begin
          if (state != ST_OUT_SEND || out_ready) begin
            if (idx_last) begin
              idx <= '0;
              col <= '0;
              row <= '0;
            end else begin
              idx <= idx + CW'(1);
              if (col + 7'd1 == num_cols) begin
                col <= '0;
                row <= row + 6'd1;
              end else begin
                col <= col + 7'd1;
              end
            end
          end
        end
        default: ;
      endcase
      if ((state == ST_ERR_SEND && out_ready) ||
          (state == ST_OUT_SEND && out_ready && idx_last)) begin
        count <= '0;
        ovf <= 1'b0;
        err_code <= STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      prob_q <= div_prob;
    end
  end

  assign prob = (state == ST_ERR_SEND) ? 16'd0 : prob_q;

  always_comb begin
    state_next = state;
    exp_start = 1'b0;
    div_start = 1'b0;
    out_valid = 1'b0;
    last_out = 1'b0;
    status = STATUS_OK;
    unique case (state)
      ST_LOAD: if (in_acc && last) state_next = ST_CHECK;
      ST_CHECK: begin
        if (chk_cnt == count) begin
          if (ovf || num_cols == '0 || rem_chk != '0) state_next = ST_ERR_SEND;
          else state_next = ST_INIT;
        end
      end
      ST_INIT: if (idx_last) state_next = ST_MAX_RD;
      ST_MAX_RD: state_next = ST_MAX_UPD;
      ST_MAX_UPD: state_next = idx_last ? ST_SUM_RD : ST_MAX_RD;
      ST_SUM_RD: state_next = ST_SUM_EXP;
      ST_SUM_EXP: begin
        exp_start = 1'b1;
        state_next = ST_SUM_UPD;
      end
      ST_SUM_UPD: state_next = idx_last ? ST_OUT_RD : ST_SUM_RD;
      ST_OUT_RD: state_next = ST_OUT_EXP;
      ST_OUT_EXP: begin
        exp_start = 1'b1;
        state_next = ST_OUT_DIV;
      end
      ST_OUT_DIV: begin
        div_start = !div_run;
        if (div_done) state_next = ST_OUT_SEND;
      end
      ST_OUT_SEND: begin
        out_valid = 1'b1;
        last_out = idx_last;
        if (out_ready) state_next = idx_last ? ST_LOAD : ST_OUT_RD;
      end
      ST_ERR_SEND: begin
        out_valid = 1'b1;
        last_out = 1'b1;
        status = err_code;
        if (out_ready) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !ready)
    else $error("output beat while loading");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ERR_SEND) |-> (err_code == STATUS_OVERFLOW ||
                               err_code == STATUS_NOT_MULTIPLE))
    else $error("error beat without error code");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_ELEMS))
    else $error("element count beyond store");
endmodule
`default_nettype wire

// ===== rtl/core/msmx_exp.sv =====
`default_nettype none
module msmx_exp (
  input  wire logic        clk,
  input  wire logic        start,
  input  wire logic [15:0] x,
  input  wire logic [15:0] mx,
  output logic [15:0]      e
);
  import msmx_pkg::*;

  logic [32:0] t;
  logic [15:0] tab_lo;
  logic [15:0] tab_hi;
  logic [3:0]  i;
  logic [11:0] r;
  logic [7:0]  k;
  logic [27:0] prod;
  logic [15:0] m;
  logic [15:0] n;

  assign n = mx - x;

  always_ff @(posedge clk) begin
    if (start) begin
      t <= {17'd0, n} * {16'd0, Log2eQ16};
    end
  end

  always_comb begin
    k = t[31:24];
    i = t[23:20];
    r = t[19:8];
    tab_hi = pow2_tab({1'b0, i});
    tab_lo = pow2_tab({1'b0, i} + 5'd1);
    prod = 28'({12'd0, tab_hi - tab_lo} * {16'd0, r}) + 28'd2048;
    m = tab_hi - prod[27:12];
    e = (t[32] == 1'b0 && k < 8'd16) ? (m >> k[3:0]) : 16'd0;
  end
endmodule
`default_nettype wire

// ===== rtl/core/msmx_div.sv =====
`default_nettype none
module msmx_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] e,
  input  wire logic [21:0] s,
  output logic             done,
  output logic [15:0]      prob
);
  import msmx_pkg::*;

  logic [38:0] num;
  logic [21:0] den;
  logic [22:0] rem;
  logic [38:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic [22:0] trial;

  assign trial = {rem[21:0], num[38]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num <= {7'd0, e, 16'd0} + {18'd0, s[21:1]};
        den <= s;
        rem <= '0;
        quo <= '0;
        cnt <= 6'd39;
      end else if (busy) begin
        num <= {num[37:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[37:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[37:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (den == '0) begin
      prob = '0;
    end else if (quo[38:16] != '0) begin
      prob = 16'hFFFF;
    end else begin
      prob = quo[15:0];
    end
  end
endmodule
`default_nettype wire
